FILE: design/i2csq_pkg.sv
// Package for the I2C script master sequencer.
// Holds transaction payload types, mode and status codes, control bit masks.
// No dependencies.
`timescale 1ns / 1ps

package i2csq_pkg;

    localparam int SCRIPT_DEPTH_DEF = 32;
    localparam int RX_DEPTH_DEF     = 8;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_EVENT = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RESTART   = 8'h10;
    localparam logic [7:0] ST_ADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_RADDR_ACK = 8'h40;
    localparam logic [7:0] ST_RDATA_ACK = 8'h50;
    localparam logic [7:0] ST_RDATA_NAK = 8'h58;

    localparam logic [7:0] CTRL_ACK   = 8'h04;
    localparam logic [7:0] CTRL_INT   = 8'h08;
    localparam logic [7:0] CTRL_STOP  = 8'h10;
    localparam logic [7:0] CTRL_START = 8'h20;
    localparam logic [7:0] CTRL_EN    = 8'h80;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] script_address;
        logic [7:0] script_byte;
        logic [7:0] bus_status;
        logic [7:0] received_byte;
    } cmd_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic [7:0] control_set;
        logic [7:0] control_clear;
        logic       store_valid;
        logic [2:0] store_index;
        logic [7:0] store_byte;
        logic       finished;
        logic       bus_error;
    } rsp_t;

endpackage

FILE: design/i2csq_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is set at instantiation; used with i2csq_pkg types.
`timescale 1ns / 1ps

interface i2csq_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/i2c_script_master_sequencer_core.sv
// Top level of the I2C script master sequencer: script store, position state,
// status decode and result register. Depends on i2csq_pkg and i2csq_chan_if.
`timescale 1ns / 1ps

// Takes one command transaction per clock and returns exactly one result
// transaction per command, through an input and then an output register; a new
// command is accepted while a result waits, and the block only holds off when
// both its input and output registers are full. The script store is two
// replicated arrays with registered read ports (three reads per step); their
// read addresses track the read position after the step in flight, with a
// bypass for a script write landing in the same cycle, so throughput stays at
// one transaction per cycle. No clearing pass: unwritten script entries read
// as don't-care.
module i2c_script_master_sequencer_core #(
    parameter int SCRIPT_DEPTH = i2csq_pkg::SCRIPT_DEPTH_DEF,
    parameter int RX_DEPTH     = i2csq_pkg::RX_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    i2csq_chan_if.sink   cmd,
    i2csq_chan_if.source rsp
);

    localparam int AW = $clog2(SCRIPT_DEPTH);
    localparam int WW = (AW > 5) ? AW : 5;
    localparam int RW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam logic [AW-1:0] POS_LAST = AW'(SCRIPT_DEPTH - 1);
    localparam logic [RW-1:0] RX_LAST  = RW'(RX_DEPTH - 1);
    localparam logic [WW:0]   DEPTH_W  = (WW + 1)'(SCRIPT_DEPTH);

    function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
        return (p == POS_LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [RW-1:0] rx_inc(input logic [RW-1:0] r);
        return (r == RX_LAST) ? '0 : r + RW'(1);
    endfunction

    // address modulo depth; address is 5 bits and depth at least 8
    function automatic logic [AW-1:0] wr_wrap(input logic [4:0] a);
        logic [WW:0] v;
        v = (WW + 1)'(a);
        for (int i = 0; i < 4; i++)
        begin
            if (v >= DEPTH_W)
            begin
                v = v - DEPTH_W;
            end
        end
        return v[AW-1:0];
    endfunction

    logic            in_valid_reg;
    i2csq_pkg::cmd_t in_payload_reg;
    logic            out_valid_reg;
    i2csq_pkg::rsp_t out_payload_reg;

    logic [AW-1:0] pos_reg, pos_next;
    logic [7:0]    left_reg, left_next;
    logic [RW-1:0] rx_reg, rx_next;

    logic [7:0] mem_a [SCRIPT_DEPTH];
    logic [7:0] mem_b [SCRIPT_DEPTH];
    logic [7:0] rd0_reg, rd1_reg, rd2_reg;
    logic       hit0_reg, hit1_reg, hit2_reg;
    logic [7:0] byp_reg;

    logic [AW-1:0] raddr0, raddr1, raddr2;
    logic [AW-1:0] p1, p2, p3;
    logic [7:0]    d0, d1, d2;
    logic          advance, proc_en, wr_en;
    logic [AW-1:0] wr_idx;
    logic [7:0]    left_dec;
    logic [RW+2:0] rx_wide;
    i2csq_pkg::rsp_t res;

    assign advance   = !out_valid_reg || rsp.ready;
    assign proc_en   = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_payload_reg;

    assign wr_en  = proc_en && (in_payload_reg.mode == i2csq_pkg::MODE_WRITE);
    assign wr_idx = wr_wrap(in_payload_reg.script_address);

    assign d0 = hit0_reg ? byp_reg : rd0_reg;
    assign d1 = hit1_reg ? byp_reg : rd1_reg;
    assign d2 = hit2_reg ? byp_reg : rd2_reg;

    assign p1 = pos_inc(pos_reg);
    assign p2 = pos_inc(p1);
    assign p3 = pos_inc(p2);
    assign left_dec = left_reg - 8'd1;
    assign rx_wide  = (RW + 3)'(rx_reg);

    always_comb
    begin
        res       = '0;
        pos_next  = pos_reg;
        left_next = left_reg;
        rx_next   = rx_reg;
        unique case (in_payload_reg.mode)
            i2csq_pkg::MODE_WRITE:
            begin
            end
            i2csq_pkg::MODE_START:
            begin
                pos_next        = '0;
                res.control_set = i2csq_pkg::CTRL_START;
            end
            i2csq_pkg::MODE_EVENT:
            begin
                res.control_clear = i2csq_pkg::CTRL_INT;
                case (in_payload_reg.bus_status) inside
                    i2csq_pkg::ST_START, i2csq_pkg::ST_RESTART:
                    begin
                        left_next         = '0;
                        rx_next           = '0;
                        res.send_valid    = 1'b1;
                        res.send_byte     = d0;
                        pos_next          = p1;
                        res.control_clear = i2csq_pkg::CTRL_INT | i2csq_pkg::CTRL_START;
                    end
                    i2csq_pkg::ST_ADDR_ACK, i2csq_pkg::ST_DATA_ACK:
                    begin
                        if (left_reg != 8'd0)
                        begin
                            res.send_valid = 1'b1;
                            res.send_byte  = d0;
                            pos_next       = p1;
                            left_next      = left_dec;
                        end
                        else if (d0 != 8'd0)
                        begin
                            res.control_set = d0;
                            res.finished    = (d0 == i2csq_pkg::CTRL_STOP);
                            pos_next        = p1;
                        end
                        else
                        begin
                            left_next      = d1;
                            res.send_valid = 1'b1;
                            res.send_byte  = d2;
                            pos_next       = p3;
                        end
                    end
                    i2csq_pkg::ST_RADDR_ACK:
                    begin
                        left_next       = d0;
                        pos_next        = p1;
                        res.control_set = (d0 != 8'd0) ? i2csq_pkg::CTRL_ACK : 8'd0;
                    end
                    i2csq_pkg::ST_RDATA_ACK:
                    begin
                        res.store_valid = 1'b1;
                        res.store_index = rx_wide[2:0];
                        res.store_byte  = in_payload_reg.received_byte;
                        rx_next         = rx_inc(rx_reg);
                        left_next       = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            res.control_clear = i2csq_pkg::CTRL_INT | i2csq_pkg::CTRL_ACK;
                        end
                    end
                    i2csq_pkg::ST_RDATA_NAK:
                    begin
                        res.store_valid = 1'b1;
                        res.store_index = rx_wide[2:0];
                        res.store_byte  = in_payload_reg.received_byte;
                        rx_next         = rx_inc(rx_reg);
                        res.control_set = d0;
                        res.finished    = (d0 == i2csq_pkg::CTRL_STOP);
                        pos_next        = p1;
                    end
                    default:
                    begin
                        res.control_set = i2csq_pkg::CTRL_STOP;
                        res.bus_error   = 1'b1;
                    end
                endcase
            end
            i2csq_pkg::MODE_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // read the window at the position left behind by this cycle's step
    assign raddr0 = proc_en ? pos_next : pos_reg;
    assign raddr1 = pos_inc(raddr0);
    assign raddr2 = pos_inc(raddr1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_idx] <= in_payload_reg.script_byte;
        end
        rd0_reg <= mem_a[raddr0];
        rd1_reg <= mem_a[raddr1];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_b[wr_idx] <= in_payload_reg.script_byte;
        end
        rd2_reg <= mem_b[raddr2];
    end

    always_ff @(posedge clk)
    begin
        hit0_reg <= wr_en && (wr_idx == raddr0);
        hit1_reg <= wr_en && (wr_idx == raddr1);
        hit2_reg <= wr_en && (wr_idx == raddr2);
        byp_reg  <= in_payload_reg.script_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            left_reg      <= '0;
            rx_reg        <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (proc_en)
            begin
                pos_reg  <= pos_next;
                left_reg <= left_next;
                rx_reg   <= rx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_payload_reg <= cmd.payload;
        end
        if (proc_en)
        begin
            out_payload_reg <= res;
        end
    end

    a_proc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc_en |=> rsp.valid)
        else $error("processed transaction produced no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (in_valid_reg && out_valid_reg && !rsp.ready))
        else $error("input stalled with free register");

    a_finish_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.finished) |->
            (rsp.payload.control_set == i2csq_pkg::CTRL_STOP))
        else $error("finished without stop code");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.bus_error) |->
            (!rsp.payload.send_valid && !rsp.payload.store_valid))
        else $error("bus error result carries send or store");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (WW + 1)'(pos_reg) < DEPTH_W)
        else $error("read position out of range");

endmodule
